// File: sv/kplc_pkg.sv
// ----------------------------------------------------------------------------
// kplc_pkg
// Shared constants and types of the key press length classifier.
// ----------------------------------------------------------------------------
package kplc_pkg;

	localparam int NUM_KEYS    = 12;
	localparam int COUNT_WIDTH = 16;

	localparam int LEVEL_W = 12;
	localparam int INDEX_W = 4;
	localparam int LIMIT_W = 16;
	localparam int MASK_W  = 12;
	localparam int CMP_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_SHORT_LIMIT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EXPIRE_LIMIT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_MASK  = 2'd2;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST  = 16'd150;
	localparam logic [LIMIT_W-1:0] EXPIRE_LIMIT_RST = 16'd1000;
	localparam logic [MASK_W-1:0]  ACTIVE_MASK_RST  = 12'hFFF;

	typedef struct packed {
		logic scan;
		logic clear;
		logic level;
		logic act;
	} kplc_ctrl_t;

	typedef struct packed {
		logic short_f;
		logic long_f;
		logic release_f;
		logic pressing;
	} kplc_status_t;

endpackage

// File: sv/key_press_length_classifier.sv
// ----------------------------------------------------------------------------
// key_press_length_classifier
// Classifies key presses as short or long from periodic scan ticks and
// reports per-key flags on read requests.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  req_type, key_levels, sel_key
//  out      out_valid/ out_stall short_press, long_press, long_release, pressing
//  cfg      APB write/read       short_limit, expire_limit, active_high_mask
//
//  One transfer per cycle on the input while in_stall is low; each item is
//  handled from the input stage register, all key lanes updating in parallel.
//  A read result is loaded into the output register when the read leaves
//  the input stage. Scan ticks produce no result.
//  Reset clears all key state and loads the register defaults.
//  A read waits in the input stage only while the output register is full
//  and stalled; a scan in the input stage never waits.
// ----------------------------------------------------------------------------
module key_press_length_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [kplc_pkg::ADDR_W-1:0] paddr,
	input  logic [kplc_pkg::DATA_W-1:0] pwdata,
	output logic [kplc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic [kplc_pkg::LEVEL_W-1:0] key_levels,
	input  logic [kplc_pkg::INDEX_W-1:0] sel_key,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        short_press,
	output logic                        long_press,
	output logic                        long_release,
	output logic                        pressing
);
	import kplc_pkg::*;

	logic [LIMIT_W-1:0] short_limit_q;
	logic [LIMIT_W-1:0] expire_limit_q;
	logic [MASK_W-1:0]  active_mask_q;

	logic               valid_s1;
	logic               req_s1;
	logic [LEVEL_W-1:0] levels_s1;
	logic [INDEX_W-1:0] index_s1;

	logic out_valid_q;
	logic short_q;
	logic long_q;
	logic release_q;
	logic pressing_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;
	logic                 s1_go;

	logic [NUM_KEYS-1:0] lv_ext;
	logic [NUM_KEYS-1:0] act_ext;
	logic [NUM_KEYS-1:0] rd_sel;
	logic [NUM_KEYS-1:0] short_vec;
	logic [NUM_KEYS-1:0] long_vec;
	logic [NUM_KEYS-1:0] release_vec;
	logic [NUM_KEYS-1:0] press_vec;

	kplc_ctrl_t   ctrl   [NUM_KEYS];
	kplc_status_t status [NUM_KEYS];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q  <= SHORT_LIMIT_RST;
			expire_limit_q <= EXPIRE_LIMIT_RST;
			active_mask_q  <= ACTIVE_MASK_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SHORT_LIMIT:  short_limit_q  <= pwdata[LIMIT_W-1:0];
				REG_EXPIRE_LIMIT: expire_limit_q <= pwdata[LIMIT_W-1:0];
				REG_ACTIVE_MASK:  active_mask_q  <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SHORT_LIMIT:  prdata = DATA_W'(short_limit_q);
			REG_EXPIRE_LIMIT: prdata = DATA_W'(expire_limit_q);
			REG_ACTIVE_MASK:  prdata = DATA_W'(active_mask_q);
			default:          prdata = '0;
		endcase
	end

	// input stage
	assign s1_go    = valid_s1 && ((req_s1 == OP_SCAN) || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1    <= req_type;
			levels_s1 <= key_levels;
			index_s1  <= sel_key;
		end
	end

	// key lanes
	assign lv_ext  = NUM_KEYS'(levels_s1);
	assign act_ext = NUM_KEYS'(active_mask_q);

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		assign rd_sel[k]      = (32'(index_s1) == k);
		assign ctrl[k].scan   = s1_go && (req_s1 == OP_SCAN);
		assign ctrl[k].clear  = s1_go && (req_s1 == OP_READ) && rd_sel[k];
		assign ctrl[k].level  = lv_ext[k];
		assign ctrl[k].act    = act_ext[k];
		assign short_vec[k]   = status[k].short_f;
		assign long_vec[k]    = status[k].long_f;
		assign release_vec[k] = status[k].release_f;
		assign press_vec[k]   = status[k].pressing;

		kplc_key_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl[k]),
			.short_limit  (short_limit_q),
			.expire_limit (expire_limit_q),
			.status       (status[k])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && (req_s1 == OP_READ)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (req_s1 == OP_READ)) begin
			short_q    <= |(short_vec & rd_sel);
			long_q     <= |(long_vec & rd_sel);
			release_q  <= |(release_vec & rd_sel);
			pressing_q <= |(press_vec & rd_sel);
		end
	end

	assign out_valid    = out_valid_q;
	assign short_press  = short_q;
	assign long_press   = long_q;
	assign long_release = release_q;
	assign pressing     = pressing_q;

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && (req_s1 == OP_READ) && out_valid_q && out_stall))
		else $error("input stalled without a blocked read");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(rd_sel))
		else $error("more than one key selected for read");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (req_s1 == OP_READ)) |=> out_valid_q)
		else $error("read did not produce a result");

endmodule

// File: sv/kplc_key_lane.sv
// ----------------------------------------------------------------------------
// kplc_key_lane
// Per-key state: last level, edge mark, sticky flags and saturating hold
// counter. Updated on a scan tick, flags cleared on a read of this key.
// ----------------------------------------------------------------------------
module kplc_key_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kplc_pkg::kplc_ctrl_t         ctrl,
	input  logic [kplc_pkg::LIMIT_W-1:0] short_limit,
	input  logic [kplc_pkg::LIMIT_W-1:0] expire_limit,
	output kplc_pkg::kplc_status_t       status
);
	import kplc_pkg::*;

	logic                   last_q;
	logic                   mark_q;
	logic                   short_q;
	logic                   long_q;
	logic                   release_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic [CMP_W-1:0] cnt_ext;
	logic             below_short;
	logic             above_short;
	logic             above_expire;
	logic             cnt_full;

	assign cnt_ext      = CMP_W'(cnt_q);
	assign below_short  = cnt_ext < CMP_W'(short_limit);
	assign above_short  = cnt_ext > CMP_W'(short_limit);
	assign above_expire = cnt_ext > CMP_W'(expire_limit);
	assign cnt_full     = &cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			mark_q    <= 1'b0;
			short_q   <= 1'b0;
			long_q    <= 1'b0;
			release_q <= 1'b0;
			cnt_q     <= '0;
		end else if (ctrl.scan) begin
			if (ctrl.level != last_q) begin
				if (ctrl.level != ctrl.act) begin
					if (below_short) begin
						short_q <= 1'b1;
					end else begin
						release_q <= 1'b1;
					end
				end
				last_q <= ctrl.level;
				mark_q <= 1'b1;
			end else if (ctrl.level == ctrl.act) begin
				if (above_short) begin
					if (mark_q) begin
						long_q <= 1'b1;
						mark_q <= 1'b0;
					end
					if (above_expire) begin
						long_q <= 1'b0;
					end else if (!cnt_full) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end else if (!cnt_full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else begin
				cnt_q <= '0;
			end
		end else if (ctrl.clear) begin
			short_q   <= 1'b0;
			long_q    <= 1'b0;
			release_q <= 1'b0;
		end
	end

	assign status.short_f   = short_q;
	assign status.long_f    = long_q;
	assign status.release_f = release_q;
	assign status.pressing  = (last_q == ctrl.act);

endmodule
